// ----- rtl/sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants of the sensor frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_EIGHT  = 8'h38;

  typedef enum logic [1:0] {
    ST_UPDATED   = 2'd0,
    ST_NO_HEADER = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_BAD_TAG   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    F_SEARCH = 3'b001,
    F_TAG    = 3'b010,
    F_BODY   = 3'b100
  } frame_phase_t;

  typedef enum logic [3:0] {
    M_IDLE  = 4'b0001,
    M_X     = 4'b0010,
    M_CHAN  = 4'b0100,
    M_COLON = 4'b1000
  } match_phase_t;

  typedef struct packed {
    logic step;
    logic clear;
  } match_ctl_t;

endpackage

// ----- rtl/sfp_match.sv -----
// ----------------------------------------------------------------------------
// sfp_match
// Body pattern matcher: "x<1..8>:1" sets the channel bit of the
// per-frame accumulator.
// ----------------------------------------------------------------------------
module sfp_match (
  input  logic              clk,
  input  logic              rst_n,
  input  sfp_pkg::match_ctl_t ctl,
  input  logic [7:0]        rx_byte,
  output logic [7:0]        acc
);

  sfp_pkg::match_phase_t phase_r, phase_nxt;
  logic [2:0]            pos_r, pos_nxt;
  logic [7:0]            acc_r, acc_nxt;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    if (ctl.clear) begin
      phase_nxt = sfp_pkg::M_IDLE;
      pos_nxt   = '0;
      acc_nxt   = '0;
    end else if (ctl.step) begin
      if (phase_r == sfp_pkg::M_COLON && rx_byte == sfp_pkg::CH_ONE) begin
        acc_nxt = acc_r | (8'd1 << pos_r);
      end
      if (rx_byte == sfp_pkg::CH_X) begin
        phase_nxt = sfp_pkg::M_X;
      end else if (phase_r == sfp_pkg::M_X &&
                   rx_byte inside {[sfp_pkg::CH_ONE:sfp_pkg::CH_EIGHT]}) begin
        pos_nxt   = 3'(rx_byte - sfp_pkg::CH_ONE);
        phase_nxt = sfp_pkg::M_CHAN;
      end else if (phase_r == sfp_pkg::M_CHAN && rx_byte == sfp_pkg::CH_COLON) begin
        phase_nxt = sfp_pkg::M_COLON;
      end else begin
        phase_nxt = sfp_pkg::M_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sfp_pkg::M_IDLE;
      pos_r   <= '0;
      acc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ----- rtl/sensor_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_parser_unit
// Byte-serial sensor frame parser with a registered result port.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while in_ready is high. Frame state
// is updated in the cycle of the input transaction, and the result of a '#'
// byte appears on the output register in the cycle after. Throughput is one
// byte per cycle; the only stall comes from the single output register:
// while it holds a result that out_ready has not taken, in_ready is low.
module sensor_frame_parser_unit #(
  parameter int BUFFER_LENGTH = 200,
  parameter int MAX_SPAN      = 60
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_sensor_bits,
  output logic [1:0] out_frame_status
);

  localparam int CNT_W  = $clog2(BUFFER_LENGTH);
  localparam int SPAN_W = $clog2(MAX_SPAN + 1);

  logic                    invert_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  sfp_pkg::frame_phase_t   phase_r, phase_nxt;
  logic                    tag_d_r, tag_d_nxt;
  logic [SPAN_W-1:0]       span_r, span_nxt;
  logic [7:0]              word_r, word_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_bits_r;
  sfp_pkg::status_t        out_status_r, status;
  logic                    accept, emit;
  logic [7:0]              acc;
  sfp_pkg::match_ctl_t     mctl;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  sfp_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .rx_byte (in_rx_byte),
    .acc     (acc)
  );

  always_comb begin
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    tag_d_nxt  = tag_d_r;
    span_nxt   = span_r;
    word_nxt   = word_r;
    status     = sfp_pkg::ST_UPDATED;
    emit       = 1'b0;
    mctl.step  = 1'b0;
    mctl.clear = 1'b0;
    if (accept) begin
      if (cnt_r >= CNT_W'(BUFFER_LENGTH - 1)) begin
        mctl.clear = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (in_rx_byte == sfp_pkg::CH_HASH) begin
          emit       = 1'b1;
          mctl.clear = 1'b1;
          if (phase_r == sfp_pkg::F_SEARCH) begin
            status = sfp_pkg::ST_NO_HEADER;
          end else if (span_r >= SPAN_W'(MAX_SPAN - 1)) begin
            status = sfp_pkg::ST_TOO_LONG;
          end else if (!tag_d_r) begin
            status = sfp_pkg::ST_BAD_TAG;
          end else begin
            status   = sfp_pkg::ST_UPDATED;
            word_nxt = invert_r ? ~acc : acc;
          end
        end else begin
          case (phase_r)
            sfp_pkg::F_SEARCH: begin
              if (in_rx_byte == sfp_pkg::CH_DOLLAR) begin
                phase_nxt = sfp_pkg::F_TAG;
                span_nxt  = SPAN_W'(1);
              end
            end
            sfp_pkg::F_TAG: begin
              tag_d_nxt = (in_rx_byte == sfp_pkg::CH_D);
              phase_nxt = sfp_pkg::F_BODY;
              if (span_r < SPAN_W'(MAX_SPAN)) span_nxt = span_r + 1'b1;
            end
            default: begin
              mctl.step = 1'b1;
              if (span_r < SPAN_W'(MAX_SPAN)) span_nxt = span_r + 1'b1;
            end
          endcase
        end
      end
      if (mctl.clear) begin
        cnt_nxt   = '0;
        phase_nxt = sfp_pkg::F_SEARCH;
        tag_d_nxt = 1'b0;
        span_nxt  = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r    <= 1'b0;
      cnt_r       <= '0;
      phase_r     <= sfp_pkg::F_SEARCH;
      tag_d_r     <= 1'b0;
      span_r      <= '0;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) invert_r <= cfg_wr_data;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      tag_d_r     <= tag_d_nxt;
      span_r      <= span_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_bits_r   <= word_nxt;
      out_status_r <= status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sensor_bits  = out_bits_r;
  assign out_frame_status = out_status_r;

endmodule

// ----- rtl/sfp_checker.sv -----
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks of the sensor frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module sfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_sensor_bits,
  input logic [1:0] out_frame_status
);

  logic [7:0] last_word_r;

  // stored word as last reported by an output transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_word_r <= '0;
    end else if (out_valid && out_ready) begin
      last_word_r <= out_sensor_bits;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sensor_bits)
      && $stable(out_frame_status))
    else $error("result changed while stalled");

  a_reject_keeps_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_frame_status != sfp_pkg::ST_UPDATED
      |-> out_sensor_bits == last_word_r)
    else $error("rejected frame changed the stored word");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output register");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_rx_byte == sfp_pkg::CH_HASH))
    else $error("result without a terminating byte");

endmodule

bind sensor_frame_parser_unit sfp_checker u_sfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_rx_byte       (in_rx_byte),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sensor_bits  (out_sensor_bits),
  .out_frame_status (out_frame_status)
);
